>>> rtl/bhq_pkg.sv
// ----------------------------------------------------------------------------
// bhq_pkg: shared types and microcode for the binary max-heap queue
// Holds the action and status codes, the control word layout, the flag group
// from the datapath and the microcode ROM that sequences every operation.
// ----------------------------------------------------------------------------
package bhq_pkg;

  // action codes of an input beat
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_PEEK   = 2'd2;

  // status codes of a result beat
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // register index of the compare mode register
  localparam logic REG_SIGNED_ORDER = 1'b0;

  // microcode steps
  typedef enum logic [4:0] {
    S_IDLE     = 5'd0,
    S_DECODE   = 5'd1,
    S_INS0     = 5'd2,
    S_INS1     = 5'd3,
    S_INS2     = 5'd4,
    S_INS_PUT  = 5'd5,
    S_DEL0     = 5'd6,
    S_DEL1     = 5'd7,
    S_DEL2     = 5'd8,
    S_SNK0     = 5'd9,
    S_SNK1     = 5'd10,
    S_SNK2     = 5'd11,
    S_SNK3     = 5'd12,
    S_SNK_PUT  = 5'd13,
    S_PK0      = 5'd14,
    S_PK1      = 5'd15,
    S_DONE     = 5'd16,
    S_FULL     = 5'd17,
    S_EMPTY    = 5'd18
  } step_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_DISPATCH,
    COND_AT_ROOT,
    COND_NO_LEFT,
    COND_NO_RIGHT,
    COND_LESS_RD_MOVE,
    COND_LESS_BEST_RD,
    COND_LESS_MOVE_BEST
  } cond_t;

  typedef enum logic [2:0] {
    ADDR_ROOT,
    ADDR_CNT,
    ADDR_PARENT,
    ADDR_CHILD,
    ADDR_RIGHT,
    ADDR_HOLE
  } addr_sel_t;

  typedef enum logic [1:0] {
    WD_MOVE,
    WD_BEST,
    WD_READ
  } wdata_sel_t;

  typedef enum logic [2:0] {
    HOLE_KEEP,
    HOLE_NEWEND,
    HOLE_ROOT,
    HOLE_PARENT,
    HOLE_CAND
  } hole_op_t;

  typedef enum logic [1:0] {
    CAND_KEEP,
    CAND_CHILD,
    CAND_RIGHT
  } cand_op_t;

  typedef enum logic [1:0] {
    CNT_KEEP,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef enum logic [1:0] {
    STAT_KEEP,
    STAT_EMPTY,
    STAT_FULL
  } stat_op_t;

  // one control word
  typedef struct packed {
    cond_t      cond;
    logic       guard;
    logic       jump;
    step_t      target;
    logic       mem_rd;
    logic       mem_wr;
    addr_sel_t  addr;
    wdata_sel_t wdata;
    hole_op_t   hole_op;
    cand_op_t   cand_op;
    cnt_op_t    cnt_op;
    logic       kmov_ld;
    logic       kbest_ld;
    logic       kout_ld;
    stat_op_t   stat_op;
    logic       emit;
  } ucode_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic [1:0] action;
    logic       full;
    logic       empty;
    logic       at_root;
    logic       no_left;
    logic       no_right;
    logic       less_rd_move;
    logic       less_best_rd;
    logic       less_move_best;
  } bhq_flags_t;

  // microcode ROM
  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    w = '0;
    unique case (s)
      S_IDLE: begin
      end
      S_DECODE: begin
        w.cond = COND_DISPATCH;
        w.jump = 1'b1;
      end
      // open a hole at the new end
      S_INS0: begin
        w.cnt_op  = CNT_INC;
        w.hole_op = HOLE_NEWEND;
      end
      // fetch the parent, stop at the root
      S_INS1: begin
        w.mem_rd = 1'b1;
        w.addr   = ADDR_PARENT;
        w.cond   = COND_AT_ROOT;
        w.jump   = 1'b1;
        w.target = S_INS_PUT;
      end
      // pull a smaller parent down and climb
      S_INS2: begin
        w.cond    = COND_LESS_RD_MOVE;
        w.guard   = 1'b1;
        w.jump    = 1'b1;
        w.target  = S_INS1;
        w.mem_wr  = 1'b1;
        w.addr    = ADDR_HOLE;
        w.wdata   = WD_READ;
        w.hole_op = HOLE_PARENT;
      end
      S_INS_PUT: begin
        w.mem_wr = 1'b1;
        w.addr   = ADDR_HOLE;
        w.wdata  = WD_MOVE;
        w.cond   = COND_ALWAYS;
        w.jump   = 1'b1;
        w.target = S_DONE;
      end
      S_DEL0: begin
        w.mem_rd = 1'b1;
        w.addr   = ADDR_ROOT;
      end
      S_DEL1: begin
        w.kout_ld = 1'b1;
        w.mem_rd  = 1'b1;
        w.addr    = ADDR_CNT;
      end
      S_DEL2: begin
        w.kmov_ld = 1'b1;
        w.cnt_op  = CNT_DEC;
        w.hole_op = HOLE_ROOT;
      end
      // fetch the left child, stop past the end
      S_SNK0: begin
        w.mem_rd  = 1'b1;
        w.addr    = ADDR_CHILD;
        w.cand_op = CAND_CHILD;
        w.cond    = COND_NO_LEFT;
        w.jump    = 1'b1;
        w.target  = S_SNK_PUT;
      end
      // hold the left child, fetch the right one
      S_SNK1: begin
        w.kbest_ld = 1'b1;
        w.mem_rd   = 1'b1;
        w.addr     = ADDR_RIGHT;
        w.cond     = COND_NO_RIGHT;
        w.jump     = 1'b1;
        w.target   = S_SNK3;
      end
      // take the right child only if strictly greater
      S_SNK2: begin
        w.cond     = COND_LESS_BEST_RD;
        w.guard    = 1'b1;
        w.kbest_ld = 1'b1;
        w.cand_op  = CAND_RIGHT;
      end
      // lift the larger child and descend
      S_SNK3: begin
        w.cond    = COND_LESS_MOVE_BEST;
        w.guard   = 1'b1;
        w.jump    = 1'b1;
        w.target  = S_SNK0;
        w.mem_wr  = 1'b1;
        w.addr    = ADDR_HOLE;
        w.wdata   = WD_BEST;
        w.hole_op = HOLE_CAND;
      end
      S_SNK_PUT: begin
        w.mem_wr = 1'b1;
        w.addr   = ADDR_HOLE;
        w.wdata  = WD_MOVE;
        w.cond   = COND_ALWAYS;
        w.jump   = 1'b1;
        w.target = S_DONE;
      end
      S_PK0: begin
        w.mem_rd = 1'b1;
        w.addr   = ADDR_ROOT;
      end
      S_PK1: begin
        w.kout_ld = 1'b1;
        w.cond    = COND_ALWAYS;
        w.jump    = 1'b1;
        w.target  = S_DONE;
      end
      S_DONE: begin
        w.emit   = 1'b1;
        w.cond   = COND_ALWAYS;
        w.jump   = 1'b1;
        w.target = S_IDLE;
      end
      S_FULL: begin
        w.stat_op = STAT_FULL;
        w.cond    = COND_ALWAYS;
        w.jump    = 1'b1;
        w.target  = S_DONE;
      end
      S_EMPTY: begin
        w.stat_op = STAT_EMPTY;
        w.cond    = COND_ALWAYS;
        w.jump    = 1'b1;
        w.target  = S_DONE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.jump   = 1'b1;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/bhq_seq.sv
// ----------------------------------------------------------------------------
// bhq_seq: microcode sequencer
// Step counter over the microcode ROM with conditional jumps and a dispatch
// jump on the latched action; issues one control word per cycle.
// ----------------------------------------------------------------------------
module bhq_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  bhq_pkg::bhq_flags_t flags,
  output bhq_pkg::ucode_t     uc,
  output logic                op_en,
  output logic                accept,
  output logic                busy
);
  import bhq_pkg::*;

  step_t pc;
  step_t pc_next;
  step_t dispatch;
  logic  cond_true;

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // evaluate the branch condition of the current word
  always_comb begin
    unique case (uc.cond)
      COND_ALWAYS:         cond_true = 1'b1;
      COND_DISPATCH:       cond_true = 1'b1;
      COND_AT_ROOT:        cond_true = flags.at_root;
      COND_NO_LEFT:        cond_true = flags.no_left;
      COND_NO_RIGHT:       cond_true = flags.no_right;
      COND_LESS_RD_MOVE:   cond_true = flags.less_rd_move;
      COND_LESS_BEST_RD:   cond_true = flags.less_best_rd;
      COND_LESS_MOVE_BEST: cond_true = flags.less_move_best;
    endcase
  end

  // pick the entry point of an operation
  always_comb begin
    unique case (flags.action)
      ACT_INSERT: dispatch = flags.full  ? S_FULL  : S_INS0;
      ACT_DELETE: dispatch = flags.empty ? S_EMPTY : S_DEL0;
      ACT_PEEK:   dispatch = flags.empty ? S_EMPTY : S_PK0;
      default:    dispatch = S_DONE;
    endcase
  end

  // next step
  always_comb begin
    if (pc == S_IDLE) begin
      pc_next = start ? S_DECODE : S_IDLE;
    end else if (uc.jump && cond_true) begin
      pc_next = (uc.cond == COND_DISPATCH) ? dispatch : uc.target;
    end else begin
      pc_next = step_t'(pc + 5'd1);
    end
  end

  // control outputs
  always_comb begin
    uc     = ucode_rom(pc);
    op_en  = !uc.guard || cond_true;
    busy   = (pc != S_IDLE);
    accept = start && (pc == S_IDLE);
  end

endmodule

>>> rtl/bhq_dpath.sv
// ----------------------------------------------------------------------------
// bhq_dpath: heap store and working registers
// Single-port key store with registered read, hole and candidate positions,
// moving and best keys, the entry count and the result registers.
// ----------------------------------------------------------------------------
module bhq_dpath #(
  parameter int HEAP_DEPTH = 256,
  parameter int KEY_WIDTH  = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [1:0]          action,
  input  logic [31:0]         key_in,
  input  bhq_pkg::ucode_t     uc,
  input  logic                op_en,
  input  logic                signed_order,
  output bhq_pkg::bhq_flags_t flags,
  output logic [31:0]         key_out,
  output logic [1:0]          status,
  output logic [8:0]          entry_count
);
  import bhq_pkg::*;

  localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int PW = CW + 1;

  logic [KEY_WIDTH-1:0] mem [HEAP_DEPTH];
  logic [KEY_WIDTH-1:0] rdata;
  logic [KEY_WIDTH-1:0] kmov;
  logic [KEY_WIDTH-1:0] kbest;
  logic [KEY_WIDTH-1:0] kout;
  logic [KEY_WIDTH-1:0] key_ext;
  logic [KEY_WIDTH-1:0] wdata;
  logic [63:0]          key_wide;
  logic [63:0]          kout_wide;
  logic [31:0]          cnt_wide;
  logic [CW-1:0]        cnt;
  logic [PW-1:0]        hole;
  logic [PW-1:0]        cand;
  logic [PW-1:0]        child;
  logic [PW-1:0]        right;
  logic [PW-1:0]        parent;
  logic [PW-1:0]        pos;
  logic [PW-1:0]        idx_full;
  logic [AW-1:0]        idx;
  logic [1:0]           action_q;
  logic [1:0]           status_q;
  logic                 en;

  // key order, optionally two's complement
  function automatic logic key_less(input logic [KEY_WIDTH-1:0] a,
                                    input logic [KEY_WIDTH-1:0] b,
                                    input logic                 sgn);
    logic [KEY_WIDTH-1:0] flip;
    flip = '0;
    flip[KEY_WIDTH-1] = sgn;
    return (a ^ flip) < (b ^ flip);
  endfunction

  // fit the key port to the key width
  assign key_wide = 64'(key_in);
  assign key_ext  = key_wide[KEY_WIDTH-1:0];

  // tree positions
  assign child  = {hole[PW-2:0], 1'b0};
  assign right  = cand + PW'(1);
  assign parent = hole >> 1;

  // address selection, one-based position to slot
  always_comb begin
    case (uc.addr)
      ADDR_ROOT:   pos = PW'(1);
      ADDR_CNT:    pos = PW'(cnt);
      ADDR_PARENT: pos = parent;
      ADDR_CHILD:  pos = child;
      ADDR_RIGHT:  pos = right;
      ADDR_HOLE:   pos = hole;
      default:     pos = hole;
    endcase
    idx_full = pos - PW'(1);
    idx      = idx_full[AW-1:0];
  end

  // write data selection
  always_comb begin
    case (uc.wdata)
      WD_MOVE: wdata = kmov;
      WD_BEST: wdata = kbest;
      WD_READ: wdata = rdata;
      default: wdata = kmov;
    endcase
  end

  assign en = op_en;

  // key store
  always_ff @(posedge clk) begin
    if (uc.mem_wr && en) begin
      mem[idx] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (uc.mem_rd) begin
      rdata <= mem[idx];
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (en) begin
      case (uc.cnt_op)
        CNT_INC: cnt <= cnt + CW'(1);
        CNT_DEC: cnt <= cnt - CW'(1);
        default: cnt <= cnt;
      endcase
    end
  end

  // hole and candidate positions
  always_ff @(posedge clk) begin
    if (en) begin
      case (uc.hole_op)
        HOLE_NEWEND: hole <= PW'(cnt) + PW'(1);
        HOLE_ROOT:   hole <= PW'(1);
        HOLE_PARENT: hole <= parent;
        HOLE_CAND:   hole <= cand;
        default:     hole <= hole;
      endcase
      case (uc.cand_op)
        CAND_CHILD: cand <= child;
        CAND_RIGHT: cand <= right;
        default:    cand <= cand;
      endcase
    end
  end

  // working keys and beat latch
  always_ff @(posedge clk) begin
    if (accept) begin
      kmov     <= key_ext;
      action_q <= action;
    end else if (uc.kmov_ld && en) begin
      kmov <= rdata;
    end
    if (uc.kbest_ld && en) begin
      kbest <= rdata;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kout     <= '0;
      status_q <= STATUS_DONE;
    end else begin
      if (uc.kout_ld && en) begin
        kout <= rdata;
      end
      case (uc.stat_op)
        STAT_EMPTY: status_q <= STATUS_EMPTY;
        STAT_FULL:  status_q <= STATUS_FULL;
        default:    status_q <= status_q;
      endcase
    end
  end

  // flags for the sequencer
  always_comb begin
    flags.action         = action_q;
    flags.full           = (cnt >= CW'(HEAP_DEPTH));
    flags.empty          = (cnt == '0);
    flags.at_root        = (hole == PW'(1));
    flags.no_left        = (child > PW'(cnt));
    flags.no_right       = (right > PW'(cnt));
    flags.less_rd_move   = key_less(rdata, kmov, signed_order);
    flags.less_best_rd   = key_less(kbest, rdata, signed_order);
    flags.less_move_best = key_less(kmov, kbest, signed_order);
  end

  // result ports
  assign kout_wide   = 64'(kout);
  assign key_out     = kout_wide[31:0];
  assign status      = status_q;
  assign cnt_wide    = 32'(cnt);
  assign entry_count = cnt_wide[8:0];

endmodule

>>> rtl/binary_max_heap_queue_core.sv
// ----------------------------------------------------------------------------
// binary_max_heap_queue_core: microcoded binary max-heap priority queue
// Insert, delete-max and peek on a one-based heap of keys, compared as
// unsigned or two's complement numbers according to a config register.
//
//   channel   | ports                                   | handshake
//   ----------+-----------------------------------------+---------------------
//   command   | action, key_in                          | start & !busy
//   result    | key_out, status, entry_count            | done, one cycle
//   config    | psel penable pwrite paddr pwdata prdata | APB, pready tied high
//
// A beat runs through the microcode one step per cycle; every step uses the
// single key store port at most once. done rises in the last step of a beat
// and busy falls in the cycle after it, when the next beat can be accepted at
// the earliest. Reset clears the count and the mode register; the key store
// has no reset. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module binary_max_heap_queue_core #(
  parameter int HEAP_DEPTH = 256,
  parameter int KEY_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [31:0] key_in,
  output logic        done,
  output logic [31:0] key_out,
  output logic [1:0]  status,
  output logic [8:0]  entry_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bhq_pkg::*;

  ucode_t     uc;
  bhq_flags_t flags;
  logic       op_en;
  logic       accept;
  logic       signed_order;
  logic       reg_sel;

  // register file
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_SIGNED_ORDER);

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_order <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      signed_order <= pwdata[0];
    end
  end

  assign prdata = reg_sel ? {31'b0, signed_order} : 32'b0;

  // sequencer
  bhq_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .flags  (flags),
    .uc     (uc),
    .op_en  (op_en),
    .accept (accept),
    .busy   (busy)
  );

  // datapath
  bhq_dpath #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .KEY_WIDTH  (KEY_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .action       (action),
    .key_in       (key_in),
    .uc           (uc),
    .op_en        (op_en),
    .signed_order (signed_order),
    .flags        (flags),
    .key_out      (key_out),
    .status       (status),
    .entry_count  (entry_count)
  );

  // result strobe
  assign done = uc.emit;

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for binary_max_heap_queue_core
// Drives insert, delete-max, peek and undefined commands through the start/busy
// port in random bursts, and mirrors the heap in a local model, in both the
// unsigned and the signed compare mode. Every done beat is checked field by
// field against the oldest expected result. The heap is filled to capacity
// and drained to empty several times.
// ----------------------------------------------------------------------------
module tb;
  import bhq_pkg::*;

  localparam int HEAP_SIZE      = 256;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int PRINT_CAP      = 100;

  // the one action code the block ignores
  localparam logic [1:0] ACT_UNDEFINED = 2'd3;

  typedef struct {
    logic [1:0]  act;
    logic [31:0] key;
  } heap_cmd_t;

  typedef struct {
    logic [31:0] key;
    logic [1:0]  stat;
    logic [8:0]  cnt;
  } heap_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  action = ACT_INSERT;
  logic [31:0] key_in = '0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic        busy;
  logic        done;
  logic [31:0] key_out;
  logic [1:0]  status;
  logic [8:0]  entry_count;
  logic [31:0] prdata;
  logic        pready;

  // commands waiting for the driver, results waiting for the monitor
  heap_cmd_t    cmd_queue[$];
  heap_result_t expected_results[$];

  // local copy of the heap and the compare mode
  logic [31:0] heap_keys [HEAP_SIZE];
  int          heap_count = 0;
  bit          signed_mode = 1'b0;

  int error_count = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int burst_left = 1;
  int gap_left = 0;

  binary_max_heap_queue_core #(
    .HEAP_DEPTH(HEAP_SIZE),
    .KEY_WIDTH (32)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .key_in     (key_in),
    .done       (done),
    .key_out    (key_out),
    .status     (status),
    .entry_count(entry_count),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // heap model
  // ---------------------------------------------------------------------------
  function automatic bit key_below(input logic [31:0] a, input logic [31:0] b);
    if (signed_mode) return $signed(a) < $signed(b);
    return a < b;
  endfunction

  task automatic swap_keys(input int x, input int y);
    logic [31:0] t;
    t = heap_keys[x - 1];
    heap_keys[x - 1] = heap_keys[y - 1];
    heap_keys[y - 1] = t;
  endtask

  // climb while the parent is strictly smaller
  task automatic swim_up(input int c);
    int p;
    p = c / 2;
    while (p >= 1 && key_below(heap_keys[p - 1], heap_keys[c - 1])) begin
      swap_keys(p, c);
      c = p;
      p = c / 2;
    end
  endtask

  // descend towards the larger child, left on a tie
  task automatic sink_down(input int p);
    int c;
    c = 2 * p;
    while (c <= heap_count) begin
      if (c + 1 <= heap_count && key_below(heap_keys[c - 1], heap_keys[c])) c = c + 1;
      if (!key_below(heap_keys[p - 1], heap_keys[c - 1])) break;
      swap_keys(p, c);
      p = c;
      c = 2 * p;
    end
  endtask

  // apply one accepted command and queue the result it must produce
  task automatic heap_command(input logic [1:0] act, input logic [31:0] key);
    heap_result_t r;
    r.key  = '0;
    r.stat = STATUS_DONE;
    case (act)
      ACT_INSERT: begin
        if (heap_count >= HEAP_SIZE) begin
          r.stat = STATUS_FULL;
        end else begin
          heap_count = heap_count + 1;
          heap_keys[heap_count - 1] = key;
          swim_up(heap_count);
        end
      end
      ACT_DELETE, ACT_PEEK: begin
        if (heap_count == 0) begin
          r.stat = STATUS_EMPTY;
        end else begin
          r.key = heap_keys[0];
          if (act == ACT_DELETE) begin
            heap_keys[0] = heap_keys[heap_count - 1];
            heap_count = heap_count - 1;
            sink_down(1);
          end
        end
      end
      default: begin
      end
    endcase
    r.cnt = heap_count[8:0];
    expected_results.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // driver: hold a command until accepted, then feed the next in bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    heap_cmd_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) heap_command(action, key_in);
      if (!(start && busy)) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          start <= 1'b0;
        end else if (cmd_queue.size() != 0) begin
          nxt = cmd_queue.pop_front();
          start  <= 1'b1;
          action <= nxt.act;
          key_in <= nxt.key;
          if (burst_left <= 1) begin
            // open a new burst, now and then a long one with no gap
            if ($urandom_range(0, 7) == 0) begin
              burst_left = $urandom_range(30, 60);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 16);
              gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
          end else begin
            burst_left = burst_left - 1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: check each result beat against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    error_count = error_count + 1;
    if (error_count <= PRINT_CAP) $display("mismatch at %0t: %s", $time, what);
  endtask

  always @(posedge clk) begin
    heap_result_t want;
    if (!rst && done) begin
      results_seen = results_seen + 1;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result beat %0d with nothing expected", results_seen));
      end else begin
        want = expected_results.pop_front();
        if (key_out !== want.key)
          report_mismatch($sformatf("beat %0d key_out %h, expected %h",
                                    results_seen, key_out, want.key));
        if (status !== want.stat)
          report_mismatch($sformatf("beat %0d status %0d, expected %0d",
                                    results_seen, status, want.stat));
        if (entry_count !== want.cnt)
          report_mismatch($sformatf("beat %0d entry_count %0d, expected %0d",
                                    results_seen, entry_count, want.cnt));
      end
    end
  end

  // watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic push_cmd(input logic [1:0] act, input logic [31:0] key);
    heap_cmd_t c;
    c.act = act;
    c.key = key;
    cmd_queue.push_back(c);
  endtask

  // hold until every command is accepted and every result has arrived
  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_queue.size() != 0 || start || busy || expected_results.size() != 0);
  endtask

  // setup and access cycle on the register port
  task automatic write_signed_order(input bit mode);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_SIGNED_ORDER, 2'b00};
    pwdata  <= {31'd0, mode};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    signed_mode = mode;
  endtask

  // mix extremes, near-sign values and small repeats for ties
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      1, 2: return 32'($urandom_range(0, 15));
      3: return 32'h7FFF_FFFC + 32'($urandom_range(0, 7));
      4: return 32'hFFFF_FFF0 + 32'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [1:0] pick_action(input int ins_pct);
    int r;
    if ($urandom_range(0, 99) < ins_pct) return ACT_INSERT;
    r = $urandom_range(0, 99);
    if (r < 4) return ACT_UNDEFINED;
    if (r < 16) return ACT_PEEK;
    return ACT_DELETE;
  endfunction

  task automatic run_phase(input bit mode, input int ins_pct, input int items);
    wait_drained();
    write_signed_order(mode);
    @(negedge clk);
    for (int i = 0; i < items; i++) push_cmd(pick_action(ins_pct), pick_key());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty heap, extremes and ties in unsigned order
    push_cmd(ACT_DELETE, 32'h1234_5678);
    push_cmd(ACT_PEEK, 32'h0000_0000);
    push_cmd(ACT_UNDEFINED, 32'hFFFF_FFFF);
    push_cmd(ACT_INSERT, 32'h0000_0000);
    push_cmd(ACT_INSERT, 32'hFFFF_FFFF);
    push_cmd(ACT_INSERT, 32'h8000_0000);
    push_cmd(ACT_INSERT, 32'h7FFF_FFFF);
    push_cmd(ACT_INSERT, 32'h0000_0005);
    push_cmd(ACT_INSERT, 32'h0000_0005);
    push_cmd(ACT_PEEK, 32'hA5A5_A5A5);
    push_cmd(ACT_UNDEFINED, 32'h0000_0000);
    for (int i = 0; i < 4; i++) push_cmd(ACT_DELETE, 32'h0000_0000);

    // same extremes in signed order, then drain past empty
    wait_drained();
    write_signed_order(1'b1);
    @(negedge clk);
    push_cmd(ACT_INSERT, 32'h8000_0000);
    push_cmd(ACT_INSERT, 32'h7FFF_FFFF);
    push_cmd(ACT_INSERT, 32'hFFFF_FFFF);
    push_cmd(ACT_PEEK, 32'h5A5A_5A5A);
    for (int i = 0; i < 6; i++) push_cmd(ACT_DELETE, 32'hFFFF_FFFF);

    // random phases: fill to capacity, drain to empty, mixed traffic
    run_phase(1'b1, 95, 330);
    run_phase(1'b0, 5, 280);
    run_phase(1'b1, 93, 300);
    run_phase(1'b0, 6, 300);
    run_phase(1'b0, 55, 120);
    run_phase(1'b1, 97, 280);
    run_phase(1'b1, 4, 220);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/bhq_pkg.sv
rtl/bhq_seq.sv
rtl/bhq_dpath.sv
rtl/binary_max_heap_queue_core.sv
test/tb.sv
